// File: hdl/rounded_rect_pixel_coverage_assert.svh
// Assertion macros for the rounded rectangle coverage block
`ifndef ROUNDED_RECT_PIXEL_COVERAGE_ASSERT_SVH
`define ROUNDED_RECT_PIXEL_COVERAGE_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset
`define RRPC_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rrpc: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset
`define RRPC_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rrpc: next-cycle check failed");

`endif

// File: hdl/rrpc_pkg.sv
// Shared constants and stage types of the rounded rectangle coverage block
`default_nettype none

package rrpc_pkg;

  localparam int COORD_BITS  = 12;
  localparam int PIXEL_BYTES = 4;

  localparam int POS_W   = 12;   // rect_left, rect_top
  localparam int SIZE_W  = 13;   // rectangle width and height
  localparam int RAD_W   = 12;   // corner_radius
  localparam int SCR_W   = 13;   // screen_width, screen_height
  localparam int DATA_W  = 32;   // fill_color, pixel_data
  localparam int OFF_W   = 26;   // byte_offset
  localparam int SQ_W    = 2 * RAD_W;
  localparam int SUM_W   = (COORD_BITS > 14 ? COORD_BITS : 14) + 1;
  localparam int PROD_W  = COORD_BITS + SCR_W;
  localparam int OFS_SUM_W = PROD_W + 1;
  localparam int OFS_W   = (OFS_SUM_W + 3 > OFF_W) ? OFS_SUM_W + 3 : OFF_W;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_LEFT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_TOP      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_W        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_H        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CORNER_RADIUS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FILL_COLOR    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd7;

  localparam logic [SCR_W-1:0] SCREEN_WIDTH_RST  = 13'd1024;
  localparam logic [SCR_W-1:0] SCREEN_HEIGHT_RST = 13'd768;

  localparam logic [DATA_W-1:0] DATA_MASK =
    DATA_W'((64'd1 << (8 * PIXEL_BYTES)) - 64'd1);

  typedef struct packed {
    logic [POS_W-1:0]  left;
    logic [POS_W-1:0]  top;
    logic [SIZE_W-1:0] width;
    logic [SIZE_W-1:0] height;
    logic [RAD_W-1:0]  radius;
    logic [SCR_W-1:0]  scr_w;
    logic [SCR_W-1:0]  scr_h;
  } geom_cfg_t;

  // First stage: rectangle tests and corner distances
  typedef struct packed {
    logic                  rad_err;
    logic                  in_rect;
    logic                  band;
    logic                  off_scr;
    logic [RAD_W-1:0]      dx;
    logic [RAD_W-1:0]      dy;
    logic [COORD_BITS-1:0] px;
    logic [COORD_BITS-1:0] py;
  } st1_t;

  // Second stage: squared distances and row product
  typedef struct packed {
    logic                  rad_err;
    logic                  in_rect;
    logic                  band;
    logic                  off_scr;
    logic [SQ_W-1:0]       dx_sq;
    logic [SQ_W-1:0]       dy_sq;
    logic [SQ_W-1:0]       r_sq;
    logic [PROD_W-1:0]     row_prod;
    logic [COORD_BITS-1:0] px;
  } st2_t;

endpackage

`default_nettype wire

// File: hdl/rounded_rect_pixel_coverage.sv
// Three register stages: geometry, squaring/row product and final
// compare/offset, each one register stage.
// Throughput: one pixel per cycle while the output is not stalled.
// A stall at the output holds each stage whose successor is full.
// Reset (rst_n low, synchronous) empties the pipe and loads register defaults.
`default_nettype none

module rounded_rect_pixel_coverage
  import rrpc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [DATA_W-1:0]     cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [COORD_BITS-1:0] in_pixel_x,
  input  logic [COORD_BITS-1:0] in_pixel_y,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_write_enable,
  output logic [OFF_W-1:0]      out_byte_offset,
  output logic [DATA_W-1:0]     out_pixel_data,
  output logic                  out_off_screen,
  output logic                  out_radius_error
);

  geom_cfg_t         cfg_r;
  logic [DATA_W-1:0] color_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.left   <= '0;
      cfg_r.top    <= '0;
      cfg_r.width  <= '0;
      cfg_r.height <= '0;
      cfg_r.radius <= '0;
      cfg_r.scr_w  <= SCREEN_WIDTH_RST;
      cfg_r.scr_h  <= SCREEN_HEIGHT_RST;
      color_r      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RECT_LEFT:     cfg_r.left   <= cfg_data[POS_W-1:0];
        REG_RECT_TOP:      cfg_r.top    <= cfg_data[POS_W-1:0];
        REG_RECT_W:        cfg_r.width  <= cfg_data[SIZE_W-1:0];
        REG_RECT_H:        cfg_r.height <= cfg_data[SIZE_W-1:0];
        REG_CORNER_RADIUS: cfg_r.radius <= cfg_data[RAD_W-1:0];
        REG_FILL_COLOR:    color_r      <= cfg_data;
        REG_SCREEN_WIDTH:  cfg_r.scr_w  <= cfg_data[SCR_W-1:0];
        REG_SCREEN_HEIGHT: cfg_r.scr_h  <= cfg_data[SCR_W-1:0];
        default:           cfg_r.left   <= cfg_r.left;
      endcase
    end
  end

  // Stage enables: a stage advances when it is empty or the next one advances
  logic out_adv, s2_adv, s1_adv;
  logic s1_valid_r, s2_valid_r, out_valid_r;
  st1_t s1_nxt, s1_r;
  st2_t s2_nxt, s2_r;

  assign out_adv  = !out_valid_r || out_ready;
  assign s2_adv   = !s2_valid_r || out_adv;
  assign s1_adv   = !s1_valid_r || s2_adv;
  assign in_ready = s1_adv;

  rrpc_geom u_geom (
    .cfg  (cfg_r),
    .px   (in_pixel_x),
    .py   (in_pixel_y),
    .geom (s1_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_adv) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && in_valid) begin
      s1_r <= s1_nxt;
    end
  end

  always_comb begin
    s2_nxt.rad_err  = s1_r.rad_err;
    s2_nxt.in_rect  = s1_r.in_rect;
    s2_nxt.band     = s1_r.band;
    s2_nxt.off_scr  = s1_r.off_scr;
    s2_nxt.dx_sq    = SQ_W'(s1_r.dx) * SQ_W'(s1_r.dx);
    s2_nxt.dy_sq    = SQ_W'(s1_r.dy) * SQ_W'(s1_r.dy);
    s2_nxt.r_sq     = SQ_W'(cfg_r.radius) * SQ_W'(cfg_r.radius);
    s2_nxt.row_prod = PROD_W'(s1_r.py) * PROD_W'(cfg_r.scr_w);
    s2_nxt.px       = s1_r.px;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_adv) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv && s1_valid_r) begin
      s2_r <= s2_nxt;
    end
  end

  // Final stage: corner compare, result codes and framebuffer offset
  logic [SQ_W:0]      dsum;
  logic               covered;
  logic [OFS_SUM_W-1:0] ofs_sum;
  logic [OFS_W-1:0]   ofs_full;
  logic               we_nxt, off_nxt, err_nxt;
  logic [OFF_W-1:0]   ofs_nxt;
  logic [DATA_W-1:0]  data_nxt;
  logic               we_r, off_r, err_r;
  logic [OFF_W-1:0]   ofs_r;
  logic [DATA_W-1:0]  data_r;

  always_comb begin
    dsum     = (SQ_W+1)'(s2_r.dx_sq) + (SQ_W+1)'(s2_r.dy_sq);
    covered  = s2_r.in_rect && (s2_r.band || (dsum <= (SQ_W+1)'(s2_r.r_sq)));
    ofs_sum  = OFS_SUM_W'(s2_r.row_prod) + OFS_SUM_W'(s2_r.px);
    ofs_full = OFS_W'(ofs_sum) * OFS_W'(PIXEL_BYTES);
    err_nxt  = s2_r.rad_err;
    we_nxt   = !s2_r.rad_err && covered && !s2_r.off_scr;
    off_nxt  = !s2_r.rad_err && covered && s2_r.off_scr;
    ofs_nxt  = we_nxt ? ofs_full[OFF_W-1:0] : '0;
    data_nxt = we_nxt ? (color_r & DATA_MASK) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && s2_valid_r) begin
      we_r   <= we_nxt;
      off_r  <= off_nxt;
      err_r  <= err_nxt;
      ofs_r  <= ofs_nxt;
      data_r <= data_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_write_enable = we_r;
  assign out_byte_offset  = ofs_r;
  assign out_pixel_data   = data_r;
  assign out_off_screen   = off_r;
  assign out_radius_error = err_r;

  `include "rounded_rect_pixel_coverage_assert.svh"

  `RRPC_ASSERT_IMPL(a_one_code, out_valid_r, !(we_r && off_r) && !(err_r && (we_r || off_r)))
  `RRPC_ASSERT_IMPL(a_no_write_zero, out_valid_r && !we_r, ofs_r == '0 && data_r == '0)
  `RRPC_ASSERT_NEXT(a_s1_hold, s1_valid_r && !s2_adv, s1_valid_r && $stable(s1_r))
  `RRPC_ASSERT_NEXT(a_s2_hold, s2_valid_r && !out_adv, s2_valid_r && $stable(s2_r))

endmodule

`default_nettype wire

// File: hdl/rrpc_geom.sv
// Rectangle, band and corner geometry for one pixel
`default_nettype none

module rrpc_geom
  import rrpc_pkg::*;
(
  input  geom_cfg_t             cfg,
  input  logic [COORD_BITS-1:0] px,
  input  logic [COORD_BITS-1:0] py,
  output st1_t                  geom
);

  logic [SUM_W-1:0] pxe, pye;
  logic [SUM_W-1:0] x_lo, x_hi, x_cl, x_cr;
  logic [SUM_W-1:0] y_lo, y_hi, y_ct, y_cb;
  logic [SUM_W-1:0] re;
  logic             lc, rc, tr, br;
  logic [SUM_W-1:0] dx_full, dy_full;

  always_comb begin
    pxe  = SUM_W'(px);
    pye  = SUM_W'(py);
    re   = SUM_W'(cfg.radius);
    x_lo = SUM_W'(cfg.left);
    x_hi = SUM_W'(cfg.left) + SUM_W'(cfg.width);
    x_cl = x_lo + re;
    x_cr = x_hi - re;
    y_lo = SUM_W'(cfg.top);
    y_hi = SUM_W'(cfg.top) + SUM_W'(cfg.height);
    y_ct = y_lo + re;
    y_cb = y_hi - re;

    lc = pxe < x_cl;
    rc = pxe >= x_cr;
    tr = pye < y_ct;
    br = pye >= y_cb;

    // Distance to the centre of whichever corner square holds the pixel
    dx_full = lc ? (x_cl - pxe) : (pxe - x_cr);
    dy_full = tr ? (y_ct - pye) : (pye - y_cb);

    geom.rad_err = ({1'b0, cfg.radius} > {1'b0, cfg.width[SIZE_W-1:1]}) ||
                   ({1'b0, cfg.radius} > {1'b0, cfg.height[SIZE_W-1:1]});
    geom.in_rect = (pxe >= x_lo) && (pxe < x_hi) && (pye >= y_lo) && (pye < y_hi);
    geom.band    = (!lc && !rc) || (!tr && !br);
    geom.off_scr = (pxe >= SUM_W'(cfg.scr_w)) || (pye >= SUM_W'(cfg.scr_h));
    geom.dx      = dx_full[RAD_W-1:0];
    geom.dy      = dy_full[RAD_W-1:0];
    geom.px      = px;
    geom.py      = py;
  end

endmodule

`default_nettype wire
